// ===== hw/rtl/conv3x3_relu_stream_core_assert.svh =====
// Assertion macros used by the checker file
`ifndef CONV3X3_RELU_STREAM_CORE_ASSERT_SVH
`define CONV3X3_RELU_STREAM_CORE_ASSERT_SVH

// property must hold on every rising clock edge outside reset
`define CRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// property checked also during reset
`define CRS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== hw/rtl/crs_pkg.sv =====
package crs_pkg;
    localparam int KERNEL_C      = 3;
    localparam int IN_CHANNELS_C = 3;
    localparam int OUT_MAPS_C    = 8;
    localparam int MAX_WIDTH_C   = 512;
    localparam int FRAC_BITS     = 12;
    localparam int DIM_W         = 10;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 10'd320;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 10'd240;

    // register byte addresses
    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;

    typedef struct packed {
        logic              kind;
        logic signed [15:0] sample_value;
        logic [7:0]        coef_index;
        logic              frame_start;
    } t_in_word;

    typedef struct packed {
        logic [14:0] feature;
        logic [2:0]  map_number;
        logic        last_map;
    } t_out_word;

    // back end states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_EMIT
    } t_be_state;

    // Q4.12 product floored back to Q4.12, wrapped to 16 bits
    function automatic logic signed [15:0] mul_q(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        logic signed [31:0] p;
        p = a * b;
        return p[FRAC_BITS+15:FRAC_BITS];
    endfunction
endpackage

// ===== hw/rtl/crs_front.sv =====
// Front end: keeps the line store and windows, hands finished windows on
module crs_front #(
    parameter int IN_CHANNELS = 3,
    parameter int MAX_WIDTH   = 512
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  crs_pkg::t_in_word       i_word,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic [9:0]              i_frame_width,
    input  logic [9:0]              i_frame_height,
    // coefficient write
    output logic                    o_coef_we,
    output logic [7:0]              o_coef_idx,
    output logic signed [15:0]      o_coef_val,
    // window handed to back end
    output logic                    o_win_valid,
    output logic [9*IN_CHANNELS*16-1:0] o_win,
    input  logic                    i_win_ready
);
    import crs_pkg::*;

    localparam int CW    = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int DEPTH = MAX_WIDTH * IN_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = 9 * IN_CHANNELS;

    // pipeline stage 1: accepted pixel, line read in flight
    logic                r_p_vld;
    logic signed [15:0]  r_p_val;
    logic [CW-1:0]       r_p_chan;
    logic                r_p_emit;
    logic [AW-1:0]       r_p_addr;
    logic [31:0]         r_rd;
    logic [31:0]         line_mem [DEPTH];

    logic [DIM_W-1:0]    r_row, r_col, n_row, n_col;
    logic [CW-1:0]       r_chan, n_chan;
    logic signed [15:0]  r_win [NW];
    logic                r_wv;
    logic                pix, busy, coef_hold;
    logic [DIM_W-1:0]    width_e, height_e;
    logic [DIM_W-1:0]    row0, col0;
    logic [CW-1:0]       chan0;
    logic [AW-1:0]       addr;
    logic [DIM_W:0]      col_inc, row_inc;

    // back pressure: hold while window waits
    assign busy   = r_wv && !i_win_ready;
    // a coefficient word waits until the back end is idle with no window pending,
    // so a position in progress keeps the weights it started with
    assign coef_hold = i_word.kind && (r_wv || !i_win_ready);
    assign o_full = busy || r_p_vld || coef_hold;
    assign pix    = i_push && !o_full && !i_word.kind;

    assign o_coef_we  = i_push && !o_full && i_word.kind;
    assign o_coef_idx = i_word.coef_index;
    assign o_coef_val = i_word.sample_value;

    // limits
    always_comb begin
        width_e = (i_frame_width < 10'd3) ? 10'd3 : i_frame_width;
        if ({1'b0, width_e} > 11'(MAX_WIDTH)) width_e = DIM_W'(MAX_WIDTH);
        height_e = (i_frame_height < 10'd3) ? 10'd3 : i_frame_height;
    end

    // position counters
    always_comb begin
        row0  = i_word.frame_start ? '0 : r_row;
        col0  = i_word.frame_start ? '0 : r_col;
        chan0 = i_word.frame_start ? '0 : r_chan;
        addr  = AW'(32'(col0[COLW-1:0]) * IN_CHANNELS + 32'(chan0));
        n_row = row0;
        n_col = col0;
        n_chan = chan0;
        col_inc = {1'b0, col0} + 1'b1;
        row_inc = {1'b0, row0} + 1'b1;
        if (32'(chan0) + 1 < IN_CHANNELS) begin
            n_chan = chan0 + 1'b1;
        end else begin
            n_chan = '0;
            if (col_inc >= {1'b0, width_e}) begin
                n_col = '0;
                n_row = (row_inc >= {1'b0, height_e}) ? '0 : row_inc[DIM_W-1:0];
            end else begin
                n_col = col_inc[DIM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_chan <= '0;
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= pix;
            if (pix) begin
                r_row <= n_row;
                r_col <= n_col;
                r_chan <= n_chan;
            end
        end
    end

    // line memory: two rows per entry, read then write back
    always_ff @(posedge i_clk) begin
        if (pix) begin
            r_rd     <= line_mem[addr];
            r_p_val  <= i_word.sample_value;
            r_p_chan <= chan0;
            r_p_addr <= addr;
            r_p_emit <= (32'(chan0) + 1 >= IN_CHANNELS) && (row0 >= 10'd2) &&
                        (col0 >= 10'd2);
        end
        if (r_p_vld) line_mem[r_p_addr] <= {r_rd[15:0], r_p_val};
    end

    // window shift for the pixel's channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
            for (int k = 0; k < NW; k++) r_win[k] <= '0;
        end else begin
            if (r_wv && i_win_ready) r_wv <= 1'b0;
            if (r_p_vld) begin
                for (int p = 0; p < 3; p++) begin
                    for (int q = 0; q < 3; q++) begin
                        if (q < 2)
                            r_win[(p*3+q)*IN_CHANNELS + 32'(r_p_chan)] <=
                                r_win[(p*3+q+1)*IN_CHANNELS + 32'(r_p_chan)];
                    end
                end
                r_win[2*IN_CHANNELS + 32'(r_p_chan)] <= r_rd[31:16];
                r_win[5*IN_CHANNELS + 32'(r_p_chan)] <= r_rd[15:0];
                r_win[8*IN_CHANNELS + 32'(r_p_chan)] <= r_p_val;
                if (r_p_emit) r_wv <= 1'b1;
            end
        end
    end

    assign o_win_valid = r_wv && !r_p_vld;
    always_comb begin
        for (int k = 0; k < NW; k++) o_win[k*16 +: 16] = r_win[k];
    end
endmodule

// ===== hw/rtl/crs_back.sv =====
// Back end: per map, bias plus one product per cycle, ReLU, one-word result register
module crs_back #(
    parameter int IN_CHANNELS = 3,
    parameter int OUT_MAPS    = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_coef_we,
    input  logic [7:0]              i_coef_idx,
    input  logic signed [15:0]      i_coef_val,
    input  logic                    i_win_valid,
    input  logic [9*IN_CHANNELS*16-1:0] i_win,
    output logic                    o_win_ready,
    output crs_pkg::t_out_word      o_word,
    output logic                    o_empty,
    input  logic                    i_pop
);
    import crs_pkg::*;

    localparam int NK  = 9;
    localparam int NW  = NK * IN_CHANNELS;
    localparam int NWT = NW * OUT_MAPS;
    localparam int TW  = $clog2(NW + 1);
    localparam int MW  = (OUT_MAPS > 1) ? $clog2(OUT_MAPS) : 1;
    localparam int WAW = $clog2(NWT);

    logic signed [15:0] wmem [NWT];
    logic signed [15:0] bias [OUT_MAPS];
    logic signed [15:0] r_win [NW];
    logic signed [15:0] r_w, r_x, r_acc;
    logic               r_pv;
    t_be_state          r_st, n_st;
    logic [TW-1:0]      r_tap;
    logic [3:0]         r_rc;
    logic [TW-1:0]      r_xc, r_xi;
    logic [MW-1:0]      r_map;
    logic [WAW-1:0]     r_wa;
    logic               r_ov;
    t_out_word          r_out;
    logic               take, fetch, done_map, emit_go;

    always_ff @(posedge i_clk) begin
        if (i_coef_we) begin
            if (32'(i_coef_idx) < NWT) wmem[WAW'(i_coef_idx)] <= i_coef_val;
            else if (32'(i_coef_idx) < NWT + OUT_MAPS)
                bias[MW'(32'(i_coef_idx) - NWT)] <= i_coef_val;
        end
    end

    assign o_win_ready = (r_st == ST_IDLE);
    assign take  = i_win_valid && o_win_ready;
    assign fetch = (r_st == ST_MAC) && (32'(r_tap) < NW);
    assign done_map = (r_st == ST_MAC) && (32'(r_tap) == NW) && !r_pv;
    assign emit_go  = (r_st == ST_EMIT) && (!r_ov || i_pop);

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (take) n_st = ST_MAC;
            ST_MAC:  if (done_map) n_st = ST_EMIT;
            ST_EMIT: if (emit_go)
                         n_st = (32'(r_map) == OUT_MAPS - 1) ? ST_IDLE : ST_MAC;
            default: n_st = ST_IDLE;
        endcase
    end

    // tap counters: weights run chan,row,col; window index r_xi runs row,col,chan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ov <= 1'b0;
            r_pv <= 1'b0;
            r_tap <= '0;
            r_rc  <= '0;
            r_xc  <= '0;
            r_xi  <= '0;
            r_map <= '0;
            r_wa  <= '0;
        end else begin
            r_st <= n_st;
            r_pv <= fetch;
            if (emit_go) r_ov <= 1'b1;
            else if (i_pop) r_ov <= 1'b0;
            if (take) begin
                r_tap <= '0;
                r_rc  <= '0;
                r_xc  <= '0;
                r_xi  <= '0;
                r_map <= '0;
                r_wa  <= '0;
            end else if (fetch) begin
                r_tap <= r_tap + 1'b1;
                r_wa  <= (32'(r_wa) == NWT - 1) ? '0 : r_wa + 1'b1;
                if (32'(r_rc) == NK - 1) begin
                    r_rc <= '0;
                    r_xc <= r_xc + 1'b1;
                    r_xi <= r_xc + 1'b1;
                end else begin
                    r_rc <= r_rc + 1'b1;
                    r_xi <= r_xi + TW'(IN_CHANNELS);
                end
            end else if (emit_go) begin
                r_tap <= '0;
                r_rc  <= '0;
                r_xc  <= '0;
                r_xi  <= '0;
                r_map <= (32'(r_map) == OUT_MAPS - 1) ? '0 : r_map + 1'b1;
            end
        end
    end

    // weight and window read into operand registers, accumulate
    always_ff @(posedge i_clk) begin
        if (take) for (int k = 0; k < NW; k++) r_win[k] <= i_win[k*16 +: 16];
        if (fetch) begin
            r_w <= wmem[r_wa];
            r_x <= r_win[r_xi];
        end
        if (r_st == ST_MAC && r_tap == '0 && !r_pv) r_acc <= bias[r_map];
        else if (r_pv) r_acc <= r_acc + mul_q(r_x, r_w);
        if (emit_go) begin
            r_out.feature    <= r_acc[15] ? '0 : r_acc[14:0];
            r_out.map_number <= 3'(r_map);
            r_out.last_map   <= (32'(r_map) == OUT_MAPS - 1);
        end
    end

    assign o_word  = r_out;
    assign o_empty = !r_ov;
endmodule

// ===== hw/rtl/conv3x3_relu_stream_core.sv =====
// A pixel word is registered with its line read, then shifts into the window. Per map the
// back end loads the bias, accumulates one product per tap and emits one word. No new
// pixel word is taken until the last one is written back; positions run one at a time
// on the single shared multiplier. A coefficient word waits until the back end is idle
// with no window pending. Reset: synchronous active low; counters and window clear,
// registers to 320x240. Line, weight and bias stores hold undefined data until written.
module conv3x3_relu_stream_core #(
    parameter int IN_CHANNELS = crs_pkg::IN_CHANNELS_C,
    parameter int OUT_MAPS    = crs_pkg::OUT_MAPS_C,
    parameter int MAX_WIDTH   = crs_pkg::MAX_WIDTH_C
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crs_pkg::t_in_word   i_word,
    input  logic                push,
    output logic                full,
    output crs_pkg::t_out_word  o_word,
    output logic                empty,
    input  logic                pop,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import crs_pkg::*;

    logic [DIM_W-1:0] r_width, r_height;
    logic             coef_we, win_valid, win_ready;
    logic [7:0]       coef_idx;
    logic signed [15:0] coef_val;
    logic [9*IN_CHANNELS*16-1:0] win;

    // config registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_WIDTH)  r_width  <= pwdata[DIM_W-1:0];
            if (paddr == ADDR_HEIGHT) r_height <= pwdata[DIM_W-1:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_WIDTH)  prdata = 32'(r_width);
        if (paddr == ADDR_HEIGHT) prdata = 32'(r_height);
    end

    crs_front #(.IN_CHANNELS(IN_CHANNELS), .MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_word, .i_push(push), .o_full(full),
        .i_frame_width(r_width), .i_frame_height(r_height),
        .o_coef_we(coef_we), .o_coef_idx(coef_idx), .o_coef_val(coef_val),
        .o_win_valid(win_valid), .o_win(win), .i_win_ready(win_ready)
    );

    crs_back #(.IN_CHANNELS(IN_CHANNELS), .OUT_MAPS(OUT_MAPS)) u_back (
        .i_clk, .i_rst_n, .i_coef_we(coef_we), .i_coef_idx(coef_idx),
        .i_coef_val(coef_val), .i_win_valid(win_valid), .i_win(win),
        .o_win_ready(win_ready), .o_word, .o_empty(empty), .i_pop(pop)
    );
endmodule

// ===== hw/rtl/crs_checker.sv =====
`include "conv3x3_relu_stream_core_assert.svh"
// Port level checks
module crs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic               pop,
    input logic               pready,
    input crs_pkg::t_out_word o_word
);
    `CRS_ASSERT_ALWAYS(a_ready_high, i_clk, pready)
    `CRS_ASSERT(a_hold, i_clk, i_rst_n, (!empty && !pop) |=> $stable(o_word))
    `CRS_ASSERT(a_last, i_clk, i_rst_n,
        (!empty && o_word.last_map) |-> (o_word.map_number == 3'd7))
    `CRS_ASSERT(a_empty_after_rst, i_clk, i_rst_n, $rose(i_rst_n) |-> empty)
endmodule

bind conv3x3_relu_stream_core crs_checker u_chk (
    .i_clk, .i_rst_n, .empty, .pop, .pready, .o_word
);

// ===== tb/conv3x3_relu_stream_core_test.sv =====
module conv3x3_relu_stream_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import crs_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE_CYC  = 300;
    localparam int HOLD_CYC    = 1500;
    localparam int N_PHASES    = 7;
    localparam logic KIND_PIX  = 1'b0;
    localparam logic KIND_COEF = 1'b1;
    localparam int N_WEIGHTS   = OUT_MAPS_C * IN_CHANNELS_C * KERNEL_C * KERNEL_C;
    // maps 0 and 1 start with zero weights so their outputs equal the bias after ReLU
    localparam int N_ZERO_W    = 2 * IN_CHANNELS_C * KERNEL_C * KERNEL_C;

    localparam int PH_WIDTH  [N_PHASES] = '{3, 0, 4, 1023, 7, 5, 3};
    localparam int PH_HEIGHT [N_PHASES] = '{3, 1, 5, 1023, 3, 4, 3};
    localparam bit PH_FS     [N_PHASES] = '{1, 1, 1, 1, 1, 1, 0};
    localparam int PH_ITEMS  [N_PHASES] = '{66, 28, 16, 6, 16, 12, 16};

    logic        i_clk;
    logic        i_rst_n;
    t_in_word    i_word;
    logic        push;
    logic        full;
    t_out_word   o_word;
    logic        empty;
    logic        pop;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    conv3x3_relu_stream_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_word),
        .push    (push),
        .full    (full),
        .o_word  (o_word),
        .empty   (empty),
        .pop     (pop),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // shadow state of the convolution
    logic signed [15:0] line_mem [2][MAX_WIDTH_C][IN_CHANNELS_C];
    logic signed [15:0] win_mem  [3][3][IN_CHANNELS_C];
    logic signed [15:0] wt_mem   [N_WEIGHTS];
    logic signed [15:0] bias_mem [OUT_MAPS_C];
    int unsigned        row_cnt, col_cnt, chan_cnt;
    logic [9:0]         cfg_width, cfg_height;

    t_out_word expected_features[$];
    int        errs;
    bit        typed_on;
    logic [14:0] typed_f0, typed_f1;
    bit        quiet;
    bit        hold_req;
    int        idle_cnt;

    // one accepted word through the convolution shadow
    task automatic conv_model_word(input t_in_word w);
        int unsigned width, height, col, c;
        logic signed [15:0] acc;
        logic signed [31:0] prod;
        t_out_word r;
        if (w.kind == KIND_COEF) begin
            if (w.coef_index < N_WEIGHTS)
                wt_mem[w.coef_index] = w.sample_value;
            else if (w.coef_index < N_WEIGHTS + OUT_MAPS_C)
                bias_mem[w.coef_index - N_WEIGHTS] = w.sample_value;
            return;
        end
        width  = (cfg_width < 3) ? 3 : ((cfg_width > MAX_WIDTH_C) ? MAX_WIDTH_C : cfg_width);
        height = (cfg_height < 3) ? 3 : cfg_height;
        if (w.frame_start) begin
            row_cnt = 0;
            col_cnt = 0;
            chan_cnt = 0;
        end
        col = col_cnt;
        c   = chan_cnt;
        // shift window left, pull in the line column and the new pixel
        for (int p = 0; p < 3; p++) begin
            win_mem[p][0][c] = win_mem[p][1][c];
            win_mem[p][1][c] = win_mem[p][2][c];
        end
        win_mem[0][2][c] = line_mem[0][col][c];
        win_mem[1][2][c] = line_mem[1][col][c];
        win_mem[2][2][c] = w.sample_value;
        line_mem[0][col][c] = line_mem[1][col][c];
        line_mem[1][col][c] = w.sample_value;
        if (c + 1 < IN_CHANNELS_C) begin
            chan_cnt = c + 1;
            return;
        end
        if (row_cnt >= 2 && col >= 2) begin
            for (int m = 0; m < OUT_MAPS_C; m++) begin
                acc = bias_mem[m];
                for (int p = 0; p < 3; p++)
                    for (int q = 0; q < 3; q++)
                        for (int ch = 0; ch < IN_CHANNELS_C; ch++) begin
                            prod = win_mem[p][q][ch] * wt_mem[((m * IN_CHANNELS_C + ch) * 3 + p) * 3 + q];
                            acc = acc + prod[27:12];
                        end
                r.feature    = (acc > 0) ? acc[14:0] : 15'd0;
                r.map_number = m[2:0];
                r.last_map   = (m == OUT_MAPS_C - 1);
                expected_features.push_back(r);
            end
        end
        chan_cnt = 0;
        col_cnt  = col + 1;
        if (col_cnt >= width) begin
            col_cnt = 0;
            row_cnt = row_cnt + 1;
            if (row_cnt >= height)
                row_cnt = 0;
        end
    endtask

    // sample both handshakes, check results, watchdog
    always @(posedge i_clk) begin
        t_out_word e;
        int k;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_features.size() == 0) begin
                    $display("%0t: unexpected word feature=%0d map=%0d last=%0b", $time,
                             o_word.feature, o_word.map_number, o_word.last_map);
                    errs++;
                end else begin
                    e = expected_features.pop_front();
                    if (o_word.feature !== e.feature) begin
                        $display("%0t: feature exp %0d got %0d", $time, e.feature, o_word.feature);
                        errs++;
                    end
                    if (o_word.map_number !== e.map_number) begin
                        $display("%0t: map_number exp %0d got %0d", $time, e.map_number,
                                 o_word.map_number);
                        errs++;
                    end
                    if (o_word.last_map !== e.last_map) begin
                        $display("%0t: last_map exp %0b got %0b", $time, e.last_map,
                                 o_word.last_map);
                        errs++;
                    end
                end
            end
            if (push && !full) begin
                conv_model_word(i_word);
                // hand-computed values override the shadow for maps 0 and 1
                if (typed_on && expected_features.size() >= OUT_MAPS_C) begin
                    k = expected_features.size() - OUT_MAPS_C;
                    expected_features[k].feature = typed_f0;
                    expected_features[k + 1].feature = typed_f1;
                end
            end
            if ((pop && !empty) || (push && !full))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pop = 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                pop = 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end else begin
                pop = 1'b1;
            end
        end
    end

    function automatic t_in_word mk_word(logic kind, logic [15:0] val, logic [7:0] idx,
                                         logic fs);
        t_in_word w;
        w.kind = kind;
        w.sample_value = val;
        w.coef_index = idx;
        w.frame_start = fs;
        return w;
    endfunction

    // offer one word, called and returning at a falling edge
    task automatic send_word(input t_in_word w);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_word = w;
        push = 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stop sending and let every pending result drain
    task automatic settle();
        push = 1'b0;
        wait (expected_features.size() == 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (addr == ADDR_WIDTH)
            cfg_width = data[9:0];
        else
            cfg_height = data[9:0];
    endtask

    task automatic apb_check(input logic [2:0] addr, input logic [9:0] val);
        psel = 1'b1;
        pwrite = 1'b0;
        penable = 1'b0;
        paddr = addr;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata[9:0] !== val) begin
            $display("%0t: reg %0d exp %0d got %0d", $time, addr, val, prdata[9:0]);
            errs++;
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    typedef struct {
        t_in_word    w;
        int          rep;
        bit          typed;
        logic [14:0] f0;
        logic [14:0] f1;
    } dir_row_t;

    initial begin
        dir_row_t dir_tbl [13];
        logic [15:0] v;

        i_rst_n = 1'b0;
        i_word = '0;
        push = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errs = 0;
        typed_on = 1'b0;
        typed_f0 = '0;
        typed_f1 = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        idle_cnt = 0;
        row_cnt = 0;
        col_cnt = 0;
        chan_cnt = 0;
        cfg_width = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        foreach (line_mem[a, b, c]) line_mem[a][b][c] = '0;
        foreach (win_mem[a, b, c]) win_mem[a][b][c] = '0;
        foreach (wt_mem[a]) wt_mem[a] = '0;
        foreach (bias_mem[a]) bias_mem[a] = '0;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // registers come up at their reset size
        apb_check(ADDR_WIDTH, WIDTH_RESET);
        apb_check(ADDR_HEIGHT, HEIGHT_RESET);

        // zero weights for maps 0 and 1, mostly small random weights elsewhere, random biases
        for (int i = 0; i < N_WEIGHTS + OUT_MAPS_C; i++) begin
            if (i < N_ZERO_W)
                v = 16'd0;
            else if (i < N_WEIGHTS)
                v = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($signed($urandom_range(0, 1023)) - 512);
            else
                v = 16'($urandom);
            send_word(mk_word(KIND_COEF, v, i[7:0], 1'b0));
        end
        settle();
        apb_write(ADDR_WIDTH, 32'd3);
        apb_write(ADDR_HEIGHT, 32'd3);

        // directed: bias extremes with zero weights, ignored indices, weight and pixel extremes
        dir_tbl[0]  = '{mk_word(KIND_COEF, 16'h7FFF, 8'd216, 1'b0), 1, 0, 0, 0};
        dir_tbl[1]  = '{mk_word(KIND_COEF, 16'h8000, 8'd217, 1'b0), 1, 0, 0, 0};
        dir_tbl[2]  = '{mk_word(KIND_COEF, 16'h04D2, 8'd240, 1'b1), 1, 0, 0, 0};
        dir_tbl[3]  = '{mk_word(KIND_COEF, 16'h5A5A, 8'd255, 1'b0), 1, 0, 0, 0};
        dir_tbl[4]  = '{mk_word(KIND_PIX, 16'h7FFF, 8'd0, 1'b1), 1, 0, 0, 0};
        dir_tbl[5]  = '{mk_word(KIND_PIX, 16'h8000, 8'd255, 1'b0), 25, 0, 0, 0};
        dir_tbl[6]  = '{mk_word(KIND_PIX, 16'h0000, 8'd0, 1'b0), 1, 1, 15'h7FFF, 15'd0};
        dir_tbl[7]  = '{mk_word(KIND_COEF, 16'h8000, 8'd0, 1'b0), 1, 0, 0, 0};
        dir_tbl[8]  = '{mk_word(KIND_COEF, 16'h7FFF, 8'd215, 1'b0), 1, 0, 0, 0};
        dir_tbl[9]  = '{mk_word(KIND_COEF, 16'h0FFF, 8'd100, 1'b0), 1, 0, 0, 0};
        dir_tbl[10] = '{mk_word(KIND_PIX, 16'h1000, 8'd0, 1'b1), 1, 0, 0, 0};
        dir_tbl[11] = '{mk_word(KIND_PIX, 16'hF000, 8'd0, 1'b0), 26, 0, 0, 0};
        dir_tbl[12] = '{mk_word(KIND_PIX, 16'h7FFF, 8'd0, 1'b0), 9, 0, 0, 0};
        foreach (dir_tbl[i]) begin
            for (int r = 0; r < dir_tbl[i].rep; r++) begin
                typed_on = dir_tbl[i].typed;
                typed_f0 = dir_tbl[i].f0;
                typed_f1 = dir_tbl[i].f1;
                send_word(dir_tbl[i].w);
                typed_on = 1'b0;
            end
        end
        settle();

        // random phases over several frame sizes; the last one shrinks mid-frame
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (PH_FS[ph])
                settle();
            else begin
                push = 1'b0;
                wait (expected_features.size() == 0);
                repeat (SETTLE_CYC) @(negedge i_clk);
            end
            apb_write(ADDR_WIDTH, 32'(PH_WIDTH[ph]));
            apb_write(ADDR_HEIGHT, 32'(PH_HEIGHT[ph]));
            if (ph == 0)
                hold_req = 1'b1;
            if (ph == N_PHASES - 1)
                quiet = 1'b1;
            for (int n = 0; n < PH_ITEMS[ph]; n++) begin
                v = ($urandom_range(0, 2) == 0) ? 16'($signed($urandom_range(0, 8191)) - 4096)
                                                : 16'($urandom);
                if ($urandom_range(0, 9) == 0)
                    send_word(mk_word(KIND_COEF, v, 8'($urandom_range(0, 255)),
                                      1'($urandom)));
                else
                    send_word(mk_word(KIND_PIX, v, 8'($urandom),
                                      (n == 0 && PH_FS[ph]) || $urandom_range(0, 49) == 0));
            end
        end

        settle();
        if (errs == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/crs_pkg.sv
hw/rtl/crs_front.sv
hw/rtl/crs_back.sv
hw/rtl/conv3x3_relu_stream_core.sv
hw/rtl/crs_checker.sv
tb/conv3x3_relu_stream_core_test.sv
